// ===== hw/rtl/bmsi_pkg.sv =====
// bmsi_pkg: constants, codes and types for the bank mapper with scanline irq
// no dependencies; used by bank_mapper_scanline_irq

package bmsi_pkg;

    // fixed sizes
    localparam int NUM_BANK_REGS  = 8;
    localparam int BANK_IDX_W     = $clog2(NUM_BANK_REGS);
    localparam int NUM_CHR_SLOTS  = 6;
    localparam int CHR_IDX_W      = $clog2(NUM_CHR_SLOTS);
    localparam int PHYS_ADDR_BITS = 19;
    localparam int CYCLE_W        = 17;
    localparam int LOW_W          = CYCLE_W + 2;

    // stream payload widths
    localparam int IN_DATA_W  = 48;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 32;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    // operation codes
    localparam logic [1:0] OP_REG_WRITE = 2'd0;
    localparam logic [1:0] OP_PPU_FETCH = 2'd1;
    localparam logic [1:0] OP_PRG_READ  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PRG_BANK_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHR_ROM_MASK   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHR_RAM_MASK   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOARD_VARIANT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OLD_IRQ_MODE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HAS_PRG_RAM    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_CYCLES   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_A12_MIN_LOW    = 3'd7;

    // board variants
    localparam logic [1:0] BOARD_CHR_ROM = 2'd0;
    localparam logic [1:0] BOARD_CHR_RAM = 2'd1;
    localparam logic [1:0] BOARD_MIXED   = 2'd2;
    localparam logic [1:0] BOARD_ALT_MIR = 2'd3;

    // cpu register windows, address bits 15:13
    localparam logic [2:0] WIN_BANK = 3'b100;
    localparam logic [2:0] WIN_MIRR = 3'b101;
    localparam logic [2:0] WIN_IRQL = 3'b110;
    localparam logic [2:0] WIN_IRQE = 3'b111;

    // reset values of the configuration registers
    localparam logic [6:0]         RST_PRG_BANK_COUNT = 7'd32;
    localparam logic [7:0]         RST_CHR_ROM_MASK   = 8'd255;
    localparam logic [7:0]         RST_CHR_RAM_MASK   = 8'd7;
    localparam logic [CYCLE_W-1:0] RST_FRAME_CYCLES   = 17'd89342;
    localparam logic [7:0]         RST_A12_MIN_LOW    = 8'd6;

    // address limits
    localparam logic [15:0] ADDR_NAMETABLE = 16'h2000;
    localparam logic [15:0] ADDR_PALETTE   = 16'h3f00;
    localparam logic [15:0] ADDR_WRAM      = 16'h6000;
    localparam logic [15:0] ADDR_PRG       = 16'h8000;

    // configuration register set
    typedef struct packed {
        logic [6:0]         prg_bank_count;
        logic [7:0]         chr_rom_mask;
        logic [7:0]         chr_ram_mask;
        logic [1:0]         board_variant;
        logic               old_irq_mode;
        logic               has_prg_ram;
        logic [CYCLE_W-1:0] frame_cycles;
        logic [7:0]         a12_min_low;
    } t_cfg;

endpackage

// ===== hw/rtl/bank_mapper_scanline_irq.sv =====
// bank_mapper_scanline_irq: cpu/ppu bank mapper with a12-clocked scanline irq counter
// depends on bmsi_pkg for codes, sizes and the configuration struct
//
// channel   | dir | handshake                    | payload
// ----------+-----+------------------------------+-------------------------------------
// s_axis    | in  | s_axis_tvalid/s_axis_tready  | tuser operation, tdata address etc.
// m_axis    | out | m_axis_tvalid/m_axis_tready  | tdata mapped address and status
// cfg       | in  | i_cfg_valid/o_cfg_ready      | i_cfg_index, i_cfg_data
//
// one item per clock unless stalled; the result is registered the cycle after the transfer
// all mapping, register and counter updates happen at the input transfer edge
// s_axis_tready drops only while a result waits and m_axis_tready is low
// i_rst_n is synchronous and active low; it clears the mapper state and loads config defaults
// the config port is always ready and takes one register per transfer

module bank_mapper_scanline_irq (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input items
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [15:0] bus_address, [23:16] write_value, [40:24] ppu_cycle, rest zero
    input  logic [bmsi_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // [1:0] operation
    input  logic [bmsi_pkg::IN_USER_W-1:0]  s_axis_tuser,
    // result items
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [18:0] phys_address, [19] use_chr_ram, [20] nametable_page, [21] irq_line,
    // [22] mirroring_mode, [23] wram_enable, [24] wram_writable, rest zero
    output logic [bmsi_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // configuration writes
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [bmsi_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bmsi_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    // configuration
    bmsi_pkg::t_cfg r_cfg;

    // mapper state
    logic [7:0]                           r_bank_select;
    logic [7:0]                           r_bank_regs [bmsi_pkg::NUM_BANK_REGS];
    logic [bmsi_pkg::NUM_CHR_SLOTS-1:0]   r_slot_is_ram;
    logic                                 r_irq_enabled;
    logic [7:0]                           r_irq_latch;
    logic                                 r_irq_reload;
    logic [7:0]                           r_irq_count;
    logic                                 r_irq_pending;
    logic                                 r_clock_next;
    logic                                 r_last_a12;
    logic [bmsi_pkg::CYCLE_W-1:0]         r_last_fall;
    logic                                 r_mirror_bit;
    logic                                 r_wram_on;
    logic                                 r_wram_wr;

    // output register
    logic                                 r_m_valid;
    logic [bmsi_pkg::OUT_DATA_W-1:0]      r_m_data;

    // next values
    logic [7:0]                           n_bank_select;
    logic                                 n_bank_wr;
    logic                                 n_slot_wr;
    logic                                 n_irq_enabled;
    logic [7:0]                           n_irq_latch;
    logic                                 n_irq_reload;
    logic [7:0]                           n_irq_count;
    logic                                 n_irq_pending;
    logic                                 n_clock_next;
    logic                                 n_last_a12;
    logic [bmsi_pkg::CYCLE_W-1:0]         n_last_fall;
    logic                                 n_mirror_bit;
    logic                                 n_wram_on;
    logic                                 n_wram_wr;
    logic [bmsi_pkg::OUT_DATA_W-1:0]      n_m_data;

    // input fields
    logic                                 in_xfer;
    logic [1:0]                           in_op;
    logic [15:0]                          in_addr;
    logic [7:0]                           in_val;
    logic [bmsi_pkg::CYCLE_W-1:0]         in_cyc;
    logic [bmsi_pkg::BANK_IDX_W-1:0]      wr_idx;

    // pattern and nametable lookup
    logic [2:0]                           chr_slot;
    logic [bmsi_pkg::BANK_IDX_W-1:0]      chr_src;
    logic [bmsi_pkg::BANK_IDX_W-1:0]      nt_src;
    logic [bmsi_pkg::BANK_IDX_W-1:0]      rd_idx;
    logic [7:0]                           rd_bank;
    logic [7:0]                           chr_bank;
    logic                                 chr_ram;
    logic                                 nt_page;

    // program lookup
    logic [6:0]                           prg_mask;
    logic [6:0]                           prg_second_last;
    logic [6:0]                           prg_last;
    logic [6:0]                           prg_bank;

    // a12 low-time measure
    logic signed [bmsi_pkg::LOW_W-1:0]    low_time;
    logic                                 low_ok;

    // outputs of the combinational result
    logic [bmsi_pkg::PHYS_ADDR_BITS-1:0]  res_phys;
    logic                                 res_ram;
    logic                                 res_page;

    assign in_xfer = s_axis_tvalid && s_axis_tready;
    assign in_op   = s_axis_tuser[1:0];
    assign in_addr = s_axis_tdata[15:0];
    assign in_val  = s_axis_tdata[23:16];
    assign in_cyc  = s_axis_tdata[40:24];
    assign wr_idx  = r_bank_select[bmsi_pkg::BANK_IDX_W-1:0];

    assign s_axis_tready = !r_m_valid || m_axis_tready;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign o_cfg_ready   = 1'b1;

    // pattern slot decode: 2 KB pairs share a register, bit 7 swaps halves
    assign chr_slot = in_addr[12:10] ^ {r_bank_select[7], 2'b00};
    assign chr_src  = chr_slot[2] ? (chr_slot - 3'd2) : {2'b00, chr_slot[1]};
    assign nt_src   = r_bank_select[7] ? ({1'b0, in_addr[11:10]} + 3'd2)
                                       : {2'b00, in_addr[11]};
    assign rd_idx   = (in_addr < bmsi_pkg::ADDR_NAMETABLE) ? chr_src : nt_src;
    assign rd_bank  = r_bank_regs[rd_idx];

    always_comb begin
        case (r_cfg.board_variant)
            bmsi_pkg::BOARD_CHR_RAM: chr_ram = 1'b1;
            bmsi_pkg::BOARD_MIXED:   chr_ram = r_slot_is_ram[chr_src];
            default:                 chr_ram = 1'b0;
        endcase
    end

    assign chr_bank = (chr_slot[2] ? rd_bank : {rd_bank[7:1], chr_slot[0]})
                    & (chr_ram ? r_cfg.chr_ram_mask : r_cfg.chr_rom_mask);
    assign nt_page  = !rd_bank[7];

    // program slot decode with the fixed banks under the count mask
    assign prg_mask        = r_cfg.prg_bank_count - 7'd1;
    assign prg_second_last = (r_cfg.prg_bank_count - 7'd2) & prg_mask;
    assign prg_last        = prg_mask;

    always_comb begin
        case (in_addr[14:13])
            2'd0:    prg_bank = r_bank_select[6] ? prg_second_last : r_bank_regs[6][6:0];
            2'd1:    prg_bank = r_bank_regs[7][6:0];
            2'd2:    prg_bank = r_bank_select[6] ? r_bank_regs[6][6:0] : prg_second_last;
            default: prg_bank = prg_last;
        endcase
    end

    // low time of a12, with the frame length added back when the cycle count wrapped
    assign low_time = $signed({2'b00, ((r_last_fall > in_cyc) ? r_cfg.frame_cycles
                                                               : {bmsi_pkg::CYCLE_W{1'b0}})})
                    + $signed({2'b00, in_cyc})
                    - $signed({2'b00, r_last_fall});
    assign low_ok   = low_time >= $signed({{(bmsi_pkg::LOW_W-8){1'b0}}, r_cfg.a12_min_low});

    // mapped address and per-fetch flags
    always_comb begin
        res_phys = '0;
        res_ram  = 1'b0;
        res_page = 1'b0;
        case (in_op)
            bmsi_pkg::OP_PPU_FETCH: begin
                if (in_addr < bmsi_pkg::ADDR_NAMETABLE) begin
                    res_phys = {1'b0, chr_bank, in_addr[9:0]};
                    res_ram  = chr_ram;
                end else if (in_addr < bmsi_pkg::ADDR_PALETTE &&
                             r_cfg.board_variant == bmsi_pkg::BOARD_ALT_MIR) begin
                    res_page = nt_page;
                end
            end
            bmsi_pkg::OP_PRG_READ: begin
                if (in_addr >= bmsi_pkg::ADDR_PRG) begin
                    res_phys = {prg_bank[5:0] & prg_mask[5:0], in_addr[12:0]};
                end else if (in_addr >= bmsi_pkg::ADDR_WRAM) begin
                    res_phys = {6'd0, in_addr[12:0]};
                end
            end
            default: begin
            end
        endcase
    end

    // register writes, counter clocking and a12 tracking
    always_comb begin
        n_bank_select = r_bank_select;
        n_bank_wr     = 1'b0;
        n_slot_wr     = 1'b0;
        n_irq_enabled = r_irq_enabled;
        n_irq_latch   = r_irq_latch;
        n_irq_reload  = r_irq_reload;
        n_irq_count   = r_irq_count;
        n_irq_pending = r_irq_pending;
        n_clock_next  = r_clock_next;
        n_last_a12    = r_last_a12;
        n_last_fall   = r_last_fall;
        n_mirror_bit  = r_mirror_bit;
        n_wram_on     = r_wram_on;
        n_wram_wr     = r_wram_wr;
        case (in_op)
            bmsi_pkg::OP_REG_WRITE: begin
                unique case (in_addr[15:13])
                    bmsi_pkg::WIN_BANK: begin
                        if (!in_addr[0]) begin
                            n_bank_select = in_val;
                        end else begin
                            n_bank_wr = 1'b1;
                            n_slot_wr = (wr_idx < 3'(bmsi_pkg::NUM_CHR_SLOTS)) &&
                                        (r_cfg.board_variant == bmsi_pkg::BOARD_MIXED);
                        end
                    end
                    bmsi_pkg::WIN_MIRR: begin
                        if (!in_addr[0]) begin
                            if (r_cfg.board_variant != bmsi_pkg::BOARD_ALT_MIR) begin
                                n_mirror_bit = !in_val[0];
                            end
                        end else if (r_cfg.has_prg_ram) begin
                            n_wram_on = in_val[7];
                            n_wram_wr = !in_val[6];
                        end
                    end
                    bmsi_pkg::WIN_IRQL: begin
                        if (!in_addr[0]) begin
                            n_irq_latch = in_val;
                        end else begin
                            n_irq_reload = 1'b1;
                            n_irq_count  = 8'd0;
                        end
                    end
                    bmsi_pkg::WIN_IRQE: begin
                        if (!in_addr[0]) begin
                            n_irq_enabled = 1'b0;
                            n_irq_pending = 1'b0;
                        end else begin
                            n_irq_enabled = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            bmsi_pkg::OP_PPU_FETCH: begin
                if (in_addr < bmsi_pkg::ADDR_PALETTE) begin
                    // counter clocked by the rise seen on an earlier fetch
                    if (r_clock_next) begin
                        n_irq_reload = 1'b0;
                        if (r_irq_count == 8'd0 || r_irq_reload) begin
                            n_irq_count = r_irq_latch;
                        end else begin
                            n_irq_count = r_irq_count - 8'd1;
                        end
                        if (r_cfg.old_irq_mode) begin
                            if ((r_irq_count != 8'd0 || r_irq_reload) &&
                                n_irq_count == 8'd0 && r_irq_enabled) begin
                                n_irq_pending = 1'b1;
                            end
                        end else if (n_irq_count == 8'd0 && r_irq_enabled) begin
                            n_irq_pending = 1'b1;
                        end
                    end
                    n_clock_next = 1'b0;
                    if (in_addr[12] && !r_last_a12) begin
                        n_clock_next = low_ok;
                    end else if (!in_addr[12] && r_last_a12) begin
                        n_last_fall = in_cyc;
                    end
                    n_last_a12 = in_addr[12];
                end
            end
            default: begin
            end
        endcase
    end

    // result word, status taken after this item
    assign n_m_data = {7'd0, n_wram_wr, n_wram_on, n_mirror_bit, n_irq_pending,
                       res_page, res_ram, res_phys};

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prg_bank_count <= bmsi_pkg::RST_PRG_BANK_COUNT;
            r_cfg.chr_rom_mask   <= bmsi_pkg::RST_CHR_ROM_MASK;
            r_cfg.chr_ram_mask   <= bmsi_pkg::RST_CHR_RAM_MASK;
            r_cfg.board_variant  <= bmsi_pkg::BOARD_CHR_ROM;
            r_cfg.old_irq_mode   <= 1'b0;
            r_cfg.has_prg_ram    <= 1'b1;
            r_cfg.frame_cycles   <= bmsi_pkg::RST_FRAME_CYCLES;
            r_cfg.a12_min_low    <= bmsi_pkg::RST_A12_MIN_LOW;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                bmsi_pkg::CFG_PRG_BANK_COUNT: r_cfg.prg_bank_count <= i_cfg_data[6:0];
                bmsi_pkg::CFG_CHR_ROM_MASK:   r_cfg.chr_rom_mask   <= i_cfg_data[7:0];
                bmsi_pkg::CFG_CHR_RAM_MASK:   r_cfg.chr_ram_mask   <= i_cfg_data[7:0];
                bmsi_pkg::CFG_BOARD_VARIANT:  r_cfg.board_variant  <= i_cfg_data[1:0];
                bmsi_pkg::CFG_OLD_IRQ_MODE:   r_cfg.old_irq_mode   <= i_cfg_data[0];
                bmsi_pkg::CFG_HAS_PRG_RAM:    r_cfg.has_prg_ram    <= i_cfg_data[0];
                bmsi_pkg::CFG_FRAME_CYCLES:   r_cfg.frame_cycles   <= i_cfg_data;
                bmsi_pkg::CFG_A12_MIN_LOW:    r_cfg.a12_min_low    <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // mapper state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank_select <= '0;
            for (int i = 0; i < bmsi_pkg::NUM_BANK_REGS; i++) begin
                r_bank_regs[i] <= '0;
            end
            r_slot_is_ram <= '0;
            r_irq_enabled <= 1'b0;
            r_irq_latch   <= '0;
            r_irq_reload  <= 1'b0;
            r_irq_count   <= '0;
            r_irq_pending <= 1'b0;
            r_clock_next  <= 1'b0;
            r_last_a12    <= 1'b0;
            r_last_fall   <= '0;
            r_mirror_bit  <= 1'b0;
            r_wram_on     <= 1'b0;
            r_wram_wr     <= 1'b0;
        end else if (in_xfer) begin
            r_bank_select <= n_bank_select;
            if (n_bank_wr) begin
                r_bank_regs[wr_idx] <= in_val;
            end
            if (n_slot_wr) begin
                r_slot_is_ram[wr_idx[bmsi_pkg::CHR_IDX_W-1:0]] <= in_val[6];
            end
            r_irq_enabled <= n_irq_enabled;
            r_irq_latch   <= n_irq_latch;
            r_irq_reload  <= n_irq_reload;
            r_irq_count   <= n_irq_count;
            r_irq_pending <= n_irq_pending;
            r_clock_next  <= n_clock_next;
            r_last_a12    <= n_last_a12;
            r_last_fall   <= n_last_fall;
            r_mirror_bit  <= n_mirror_bit;
            r_wram_on     <= n_wram_on;
            r_wram_wr     <= n_wram_wr;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_m_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_m_data <= n_m_data;
        end
    end

    // a pending counter clock always follows a rise of a12
    a_clock_after_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clock_next |-> r_last_a12)
        else $error("counter clock armed while a12 is low");

    // the interrupt is only raised while enabled
    a_pending_enabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_irq_pending) |-> r_irq_enabled)
        else $error("irq raised while disabled");

    // a reload request keeps the counter at zero until the next clock
    a_reload_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_irq_reload |-> (r_irq_count == 8'd0))
        else $error("counter nonzero with reload pending");

    // a taken result with no new transfer empties the output register
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !s_axis_tvalid) |=> !m_axis_tvalid)
        else $error("result repeated after transfer");

endmodule

// ===== dv/bank_mapper_scanline_irq_tb.sv =====
// bank_mapper_scanline_irq_tb: self-checking bench for the bank mapper with scanline irq
// drives bus items and config writes, predicts every mapped result and checks each transfer
// depends on bmsi_pkg and bank_mapper_scanline_irq

module bank_mapper_scanline_irq_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bmsi_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT   = 5000;
    localparam int DRAIN_CYCLES     = 8;
    localparam int PHASE_COUNT      = 8;
    localparam int ITEMS_PER_PHASE  = 150;

    typedef struct packed {
        logic [1:0]         op;
        logic [15:0]        addr;
        logic [7:0]         wdata;
        logic [CYCLE_W-1:0] cycle;
    } t_bus_item;

    typedef struct packed {
        logic [PHYS_ADDR_BITS-1:0] phys;
        logic                      chr_ram;
        logic                      nt_page;
        logic                      irq;
        logic                      mirr;
        logic                      wram_en;
        logic                      wram_wr;
    } t_bus_result;

    // dut connections
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [IN_USER_W-1:0]  s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // item traffic and bookkeeping
    t_bus_item   bus_items[$];
    t_bus_result mapped_results[$];
    t_bus_item   held_item;
    t_bus_result expected_map;
    int          mismatches = 0;
    int          stall_cycles = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          send_pct_tbl[4] = '{0, 66, 0, 21};
    int          recv_pct_tbl[4] = '{0, 0, 66, 21};

    // mapper state as predicted
    t_cfg               model_cfg;
    logic [7:0]         bank_sel;
    logic [7:0]         bank_reg [8];
    logic               slot_ram [6];
    logic               irq_en, irq_reload, irq_pend, arm_clock, prev_a12;
    logic               mirr_bit, wram_on_q, wram_wr_q;
    logic [7:0]         irq_latch, irq_cnt;
    logic [CYCLE_W-1:0] fall_cycle;

    bank_mapper_scanline_irq dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        // [15:0] bus_address, [23:16] write_value, [40:24] ppu_cycle, rest zero
        .s_axis_tdata  (s_axis_tdata),
        // [1:0] operation
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        // [18:0] phys_address, [19] use_chr_ram, [20] nametable_page, [21] irq_line,
        // [22] mirroring_mode, [23] wram_enable, [24] wram_writable, rest zero
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // predict one item: updates the mapper state and returns the mapped result
    function automatic t_bus_result map_bus_item(input t_bus_item it);
        t_bus_result res;
        logic        a12;
        logic [7:0]  prior_cnt;
        int          fc, lf, cy, low_time;
        logic [2:0]  slot, src, nt_reg;
        logic [7:0]  bank;
        logic        ram;
        logic [6:0]  pmask, p_second;
        logic [20:0] wide;
        res = '0;
        case (it.op)
            OP_REG_WRITE: begin
                case (it.addr[15:13])
                    WIN_BANK: begin
                        if (!it.addr[0]) begin
                            bank_sel = it.wdata;
                        end else begin
                            bank_reg[bank_sel[2:0]] = it.wdata;
                            if (bank_sel[2:0] < 3'd6 && model_cfg.board_variant == BOARD_MIXED)
                                slot_ram[bank_sel[2:0]] = it.wdata[6];
                        end
                    end
                    WIN_MIRR: begin
                        if (!it.addr[0]) begin
                            if (model_cfg.board_variant != BOARD_ALT_MIR)
                                mirr_bit = ~it.wdata[0];
                        end else if (model_cfg.has_prg_ram) begin
                            wram_on_q = it.wdata[7];
                            wram_wr_q = ~it.wdata[6];
                        end
                    end
                    WIN_IRQL: begin
                        if (!it.addr[0]) begin
                            irq_latch = it.wdata;
                        end else begin
                            irq_reload = 1'b1;
                            irq_cnt = 8'd0;
                        end
                    end
                    WIN_IRQE: begin
                        if (!it.addr[0]) begin
                            irq_en = 1'b0;
                            irq_pend = 1'b0;
                        end else begin
                            irq_en = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            OP_PPU_FETCH: begin
                // a12 tracking and the delayed counter clock, palette fetches excluded
                if (it.addr < ADDR_PALETTE) begin
                    a12 = it.addr[12];
                    if (arm_clock) begin
                        arm_clock = 1'b0;
                        prior_cnt = irq_cnt;
                        if (irq_cnt == 8'd0 || irq_reload)
                            irq_cnt = irq_latch;
                        else
                            irq_cnt = irq_cnt - 8'd1;
                        // old revision fires only when the count reaches zero
                        if (irq_cnt == 8'd0 && irq_en &&
                            (!model_cfg.old_irq_mode || prior_cnt != 8'd0 || irq_reload))
                            irq_pend = 1'b1;
                        irq_reload = 1'b0;
                    end
                    if (a12 != prev_a12) begin
                        if (a12) begin
                            fc = model_cfg.frame_cycles;
                            lf = fall_cycle;
                            cy = it.cycle;
                            // wrapped frame may give a negative low time
                            low_time = (lf > cy) ? (fc - lf + cy) : (cy - lf);
                            if (low_time >= int'(model_cfg.a12_min_low))
                                arm_clock = 1'b1;
                        end else begin
                            fall_cycle = it.cycle;
                        end
                    end
                    prev_a12 = a12;
                end
                // pattern fetch through the eight 1 KB slots
                if (it.addr < ADDR_NAMETABLE) begin
                    slot = it.addr[12:10] ^ {bank_sel[7], 2'b00};
                    if (slot < 3'd4) begin
                        src = {2'b00, slot[1]};
                        bank = {bank_reg[src][7:1], slot[0]};
                    end else begin
                        src = slot - 3'd2;
                        bank = bank_reg[src];
                    end
                    ram = (model_cfg.board_variant == BOARD_CHR_RAM) ||
                          (model_cfg.board_variant == BOARD_MIXED && slot_ram[src]);
                    bank = bank & (ram ? model_cfg.chr_ram_mask : model_cfg.chr_rom_mask);
                    res.phys = {1'b0, bank, it.addr[9:0]};
                    res.chr_ram = ram;
                end else if (it.addr < ADDR_PALETTE &&
                             model_cfg.board_variant == BOARD_ALT_MIR) begin
                    nt_reg = bank_sel[7] ? (3'd2 + {1'b0, it.addr[11:10]})
                                         : {2'b00, it.addr[11]};
                    res.nt_page = ~bank_reg[nt_reg][7];
                end
            end
            OP_PRG_READ: begin
                // program window through four 8 KB slots
                if (it.addr >= ADDR_PRG) begin
                    pmask = model_cfg.prg_bank_count - 7'd1;
                    p_second = (model_cfg.prg_bank_count - 7'd2) & pmask;
                    case (it.addr[14:13])
                        2'd0:    bank = bank_sel[6] ? {1'b0, p_second} : bank_reg[6];
                        2'd1:    bank = bank_reg[7];
                        2'd2:    bank = bank_sel[6] ? bank_reg[6] : {1'b0, p_second};
                        default: bank = {1'b0, pmask};
                    endcase
                    bank = bank & {1'b0, pmask};
                    wide = {bank, it.addr[12:0]};
                    res.phys = wide[PHYS_ADDR_BITS-1:0];
                end else if (it.addr >= ADDR_WRAM) begin
                    res.phys = {6'd0, it.addr[12:0]};
                end
            end
            default: ;
        endcase
        res.irq = irq_pend;
        res.mirr = mirr_bit;
        res.wram_en = wram_on_q;
        res.wram_wr = wram_wr_q;
        return res;
    endfunction

    function automatic void push_item(input logic [1:0] op, input logic [15:0] addr,
                                      input logic [7:0] wdata, input logic [CYCLE_W-1:0] cycle);
        t_bus_item it;
        it.op = op;
        it.addr = addr;
        it.wdata = wdata;
        it.cycle = cycle;
        bus_items.push_back(it);
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, want, got);
            mismatches++;
        end
    endtask

    // config write, mirrored into the predictor at the transfer edge
    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value[CFG_DATA_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_PRG_BANK_COUNT: model_cfg.prg_bank_count = value[6:0];
            CFG_CHR_ROM_MASK:   model_cfg.chr_rom_mask = value[7:0];
            CFG_CHR_RAM_MASK:   model_cfg.chr_ram_mask = value[7:0];
            CFG_BOARD_VARIANT:  model_cfg.board_variant = value[1:0];
            CFG_OLD_IRQ_MODE:   model_cfg.old_irq_mode = value[0];
            CFG_HAS_PRG_RAM:    model_cfg.has_prg_ram = value[0];
            CFG_FRAME_CYCLES:   model_cfg.frame_cycles = value[CYCLE_W-1:0];
            default:            model_cfg.a12_min_low = value[7:0];
        endcase
    endtask

    // wait until every queued item is sent and every result is back
    task automatic wait_drained();
        do @(posedge i_clk);
        while (bus_items.size() != 0 || s_axis_tvalid || mapped_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                mapped_results.push_back(map_bus_item(held_item));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (bus_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    held_item = bus_items.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser <= held_item.op;
                    s_axis_tdata <= {7'd0, held_item.cycle, held_item.wdata, held_item.addr};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (mapped_results.size() == 0) begin
                    $display("%0t: result transfer, expected none, actual %0h",
                             $realtime, m_axis_tdata);
                    mismatches++;
                end else begin
                    expected_map = mapped_results.pop_front();
                    compare_field("phys_address", expected_map.phys, m_axis_tdata[18:0]);
                    compare_field("use_chr_ram", expected_map.chr_ram, m_axis_tdata[19]);
                    compare_field("nametable_page", expected_map.nt_page, m_axis_tdata[20]);
                    compare_field("irq_line", expected_map.irq, m_axis_tdata[21]);
                    compare_field("mirroring_mode", expected_map.mirr, m_axis_tdata[22]);
                    compare_field("wram_enable", expected_map.wram_en, m_axis_tdata[23]);
                    compare_field("wram_writable", expected_map.wram_wr, m_axis_tdata[24]);
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // cycles without any transfer
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin : watchdog
        wait (stall_cycles >= WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : stimulus
        int         ppu_pos, fr, pick, sub;
        logic       cur_a12;
        logic [15:0] addr;
        logic [7:0] wdata;
        logic [CYCLE_W-1:0] cyc;
        int         count_v, rom_v, ram_v, var_v, old_v, has_v, frame_v, minlow_v;

        // predictor state after reset
        model_cfg.prg_bank_count = RST_PRG_BANK_COUNT;
        model_cfg.chr_rom_mask = RST_CHR_ROM_MASK;
        model_cfg.chr_ram_mask = RST_CHR_RAM_MASK;
        model_cfg.board_variant = BOARD_CHR_ROM;
        model_cfg.old_irq_mode = 1'b0;
        model_cfg.has_prg_ram = 1'b1;
        model_cfg.frame_cycles = RST_FRAME_CYCLES;
        model_cfg.a12_min_low = RST_A12_MIN_LOW;
        bank_sel = '0;
        for (int k = 0; k < 8; k++) bank_reg[k] = '0;
        for (int k = 0; k < 6; k++) slot_ram[k] = 1'b0;
        irq_en = 0; irq_reload = 0; irq_pend = 0; arm_clock = 0; prev_a12 = 0;
        mirr_bit = 0; wram_on_q = 0; wram_wr_q = 0;
        irq_latch = '0; irq_cnt = '0; fall_cycle = '0;
        ppu_pos = 0;
        cur_a12 = 1'b0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // directed items on the reset configuration
        push_item(OP_REG_WRITE, 16'h8000, 8'hc7, 17'd0);       // select reg 7, both swaps
        push_item(OP_REG_WRITE, 16'h8001, 8'hff, 17'h1ffff);
        push_item(OP_REG_WRITE, 16'ha000, 8'h00, 17'd0);
        push_item(OP_REG_WRITE, 16'ha001, 8'h80, 17'd0);
        push_item(OP_REG_WRITE, 16'hc000, 8'h00, 17'd0);
        push_item(OP_REG_WRITE, 16'hc001, 8'h00, 17'd0);
        push_item(OP_REG_WRITE, 16'he001, 8'h00, 17'd0);
        push_item(OP_REG_WRITE, 16'h7fff, 8'hff, 17'd0);       // below the register windows
        push_item(OP_UNUSED, 16'hffff, 8'hff, 17'h1ffff);
        push_item(OP_PPU_FETCH, 16'h0000, 8'h00, 17'd0);
        push_item(OP_PPU_FETCH, 16'h1000, 8'h00, 17'd10);      // qualifying a12 rise
        push_item(OP_PPU_FETCH, 16'h1fff, 8'h00, 17'd11);      // delayed counter clock
        push_item(OP_PPU_FETCH, 16'h0fff, 8'h00, 17'h1ffff);   // fall at the top cycle
        push_item(OP_PPU_FETCH, 16'h1000, 8'h00, 17'd3);       // wrapped, negative low time
        push_item(OP_PPU_FETCH, 16'h2000, 8'h00, 17'd20);
        push_item(OP_PPU_FETCH, 16'h3eff, 8'h00, 17'd21);
        push_item(OP_PPU_FETCH, 16'h3f00, 8'h00, 17'd22);      // palette
        push_item(OP_PPU_FETCH, 16'hffff, 8'hff, 17'd23);
        push_item(OP_PRG_READ, 16'h0000, 8'h00, 17'd0);
        push_item(OP_PRG_READ, 16'h6000, 8'h00, 17'd0);
        push_item(OP_PRG_READ, 16'h8000, 8'h00, 17'd0);
        push_item(OP_PRG_READ, 16'ha000, 8'h00, 17'd0);
        push_item(OP_PRG_READ, 16'hc000, 8'h00, 17'd0);
        push_item(OP_PRG_READ, 16'hffff, 8'h00, 17'd0);
        push_item(OP_REG_WRITE, 16'he000, 8'h00, 17'd0);       // irq acknowledge
        wait_drained();

        for (int p = 0; p < PHASE_COUNT; p++) begin
            // configuration of this phase, extremes first
            case (p)
                0: begin
                    count_v = 2; rom_v = 0; ram_v = 0; var_v = BOARD_CHR_ROM;
                    old_v = 0; has_v = 1; frame_v = 1; minlow_v = 0;
                end
                1: begin
                    count_v = 64; rom_v = 255; ram_v = 255; var_v = BOARD_ALT_MIR;
                    old_v = 1; has_v = 0; frame_v = 131071; minlow_v = 255;
                end
                default: begin
                    count_v = ($urandom_range(99) < 75) ? (1 << $urandom_range(1, 6))
                                                        : $urandom_range(0, 127);
                    rom_v = $urandom_range(0, 255);
                    ram_v = $urandom_range(0, 255);
                    var_v = p % 4;
                    old_v = $urandom_range(0, 1);
                    has_v = ($urandom_range(99) < 80);
                    frame_v = ($urandom_range(0, 1) != 0) ? 89342 : $urandom_range(1, 131071);
                    minlow_v = ($urandom_range(99) < 80) ? $urandom_range(0, 20)
                                                         : $urandom_range(0, 255);
                end
            endcase
            write_cfg(CFG_PRG_BANK_COUNT, count_v);
            write_cfg(CFG_CHR_ROM_MASK, rom_v);
            write_cfg(CFG_CHR_RAM_MASK, ram_v);
            write_cfg(CFG_BOARD_VARIANT, var_v);
            write_cfg(CFG_OLD_IRQ_MODE, old_v);
            write_cfg(CFG_HAS_PRG_RAM, has_v);
            write_cfg(CFG_FRAME_CYCLES, frame_v);
            write_cfg(CFG_A12_MIN_LOW, minlow_v);

            send_idle_pct = send_pct_tbl[(p / 2) % 4];
            recv_stall_pct = recv_pct_tbl[(p / 2) % 4];
            fr = model_cfg.frame_cycles;
            ppu_pos = ppu_pos % fr;

            // rendering-like fetch runs mixed with register writes and program lookups
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                pick = $urandom_range(99);
                if (pick < 45) begin
                    if ($urandom_range(99) < 5)
                        ppu_pos = $urandom_range(0, fr - 1);
                    else
                        ppu_pos = (ppu_pos + $urandom_range(0, 10)) % fr;
                    if ($urandom_range(99) < 25) cur_a12 = ~cur_a12;
                    sub = $urandom_range(99);
                    if (sub < 78)
                        addr = {3'b000, cur_a12, 12'($urandom)};
                    else if (sub < 95)
                        addr = 16'h2000 + 16'($urandom_range(0, 16'h1eff));
                    else
                        addr = 16'($urandom_range(16'h3f00, 16'hffff));
                    cyc = ($urandom_range(99) < 3) ? 17'($urandom) : 17'(ppu_pos);
                    push_item(OP_PPU_FETCH, addr, 8'($urandom), cyc);
                end else if (pick < 75) begin
                    if ($urandom_range(99) < 5)
                        addr = 16'($urandom_range(0, 16'h7fff));
                    else
                        addr = 16'h8000 | 16'($urandom_range(0, 16'h7fff));
                    // short latch values so the counter fires often
                    if (addr[15:13] == WIN_IRQL && !addr[0] && $urandom_range(99) < 80)
                        wdata = 8'($urandom_range(0, 8));
                    else
                        wdata = 8'($urandom);
                    push_item(OP_REG_WRITE, addr, wdata, 17'($urandom));
                end else if (pick < 97) begin
                    if ($urandom_range(99) < 75)
                        addr = 16'h8000 | 16'($urandom_range(0, 16'h7fff));
                    else
                        addr = 16'($urandom);
                    push_item(OP_PRG_READ, addr, 8'($urandom), 17'($urandom));
                end else begin
                    push_item(OP_UNUSED, 16'($urandom), 8'($urandom), 17'($urandom));
                end
            end
            wait_drained();
        end

        if (mapped_results.size() != 0) begin
            $display("%0t: results outstanding, expected 0, actual %0d",
                     $realtime, mapped_results.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
